// File: src/fmp_pkg.sv
package fmp_pkg;
  localparam int EXP_BITS_DEF = 63;
  localparam int MOD_BITS_DEF = 31;
endpackage

// File: src/fmp_if.sv
interface fmp_in_if #(parameter int EXP_BITS = 63, parameter int MOD_BITS = 31);
  logic                valid;
  logic                ready;
  logic [EXP_BITS-1:0] exponent;
  logic [MOD_BITS-1:0] modulus;
  logic [30:0]         given_top_left;
  logic [30:0]         given_top_right;
  logic [30:0]         given_bottom_left;
  logic [30:0]         given_bottom_right;
  modport source (output valid, exponent, modulus, given_top_left, given_top_right,
                  given_bottom_left, given_bottom_right, input ready);
  modport sink (input valid, exponent, modulus, given_top_left, given_top_right,
                given_bottom_left, given_bottom_right, output ready);
endinterface

interface fmp_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] out_top_left;
  logic [30:0] out_top_right;
  logic [30:0] out_bottom_left;
  logic [30:0] out_bottom_right;
  modport source (output valid, out_top_left, out_top_right, out_bottom_left,
                  out_bottom_right, input ready);
  modport sink (input valid, out_top_left, out_top_right, out_bottom_left,
                out_bottom_right, output ready);
endinterface

// File: src/fmp_modred.sv
// shared reducer: x mod m, one quotient bit per cycle, restoring
module fmp_modred #(
  parameter int MOD_BITS = fmp_pkg::MOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*MOD_BITS:0]   x,
  input  logic [MOD_BITS-1:0]   m,
  output logic                  done,
  output logic [MOD_BITS-1:0]   r
);
  localparam int XW = 2 * MOD_BITS + 1;
  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0]   sh;
  logic [MOD_BITS:0] rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [MOD_BITS+1:0] trial;
  logic [MOD_BITS:0] rem_next;

  always_comb begin
    trial = {rem, sh[XW-1]} - {2'b00, m};
    if (!trial[MOD_BITS+1]) rem_next = trial[MOD_BITS:0];
    else rem_next = {rem[MOD_BITS-1:0], sh[XW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sh   <= x;
        rem  <= '0;
        cnt  <= CW'(XW);
      end else if (busy) begin
        rem <= rem_next;
        sh  <= {sh[XW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign r = rem[MOD_BITS-1:0];
endmodule

// File: src/fibonacci_matrix_power_mod.sv
// fibonacci matrix power modulo m
// in channel: exponent b, modulus m and a 2x2 matrix g, one word per item
// out channel: one 2x2 matrix word per item
//   b == 0 or m == 0 : zero matrix
//   b == 1           : g reduced mod m entry by entry
//   b >= 2           : [[1,1],[1,0]]^b mod m, square-and-multiply msb first
// one shared multiplier pair feeds one shared bit-serial reducer; every product sum
// and every add is reduced there, one entry job at a time
// the top set bit of b is searched one position per cycle, then per exponent bit
// below the top one come 4 square jobs plus 4 more when the bit is set;
// b == 1 needs 4 jobs, and b == 0 or m == 0 gives the result straight from the search
// in.ready is high only while idle; one item is worked at a time
// the result sits in the output register until taken; a stalled receiver holds
// the block busy but loses nothing
// reset (synchronous, active high) returns to idle with no output pending
module fibonacci_matrix_power_mod #(
  parameter int EXP_BITS = fmp_pkg::EXP_BITS_DEF,
  parameter int MOD_BITS = fmp_pkg::MOD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  fmp_in_if.sink  in,
  fmp_out_if.source out
);
  localparam int MW = MOD_BITS;
  localparam int XW = 2 * MOD_BITS + 1;
  localparam int BW = $clog2(EXP_BITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TOP  = 6'b000010,
    S_LOAD = 6'b000100,
    S_RED  = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [EXP_BITS-1:0] b;
  logic [MW-1:0] m;
  logic [MW-1:0] a [4];    // working matrix
  logic [MW-1:0] na [4];   // next matrix under construction
  logic [30:0]  g [4];
  logic [BW-1:0] bit_idx;
  logic [2:0]   job;       // entry being reduced
  logic         phase_mul; // 0: square, 1: multiply by fib
  logic         direct;    // reducing given matrix
  logic         red_start, red_done;
  logic [XW-1:0] red_x;
  logic [MW-1:0] red_r;
  logic [2*MW-1:0] p0, p1;
  logic [MW-1:0] ma, mb, mc, md;

  // shared multiplier pair operand select for the square step
  always_comb begin
    ma = a[0]; mb = a[0]; mc = a[1]; md = a[2];
    unique case (job[1:0])
      2'd0: begin ma = a[0]; mb = a[0]; mc = a[1]; md = a[2]; end
      2'd1: begin ma = a[0]; mb = a[1]; mc = a[1]; md = a[3]; end
      2'd2: begin ma = a[2]; mb = a[0]; mc = a[3]; md = a[2]; end
      default: begin ma = a[2]; mb = a[1]; mc = a[3]; md = a[3]; end
    endcase
  end

  always_ff @(posedge clk) begin
    p0 <= ma * mb;
    p1 <= mc * md;
  end

  always_comb begin
    if (direct) red_x = XW'(g[job[1:0]]);
    else if (phase_mul) begin
      // lower row takes the old upper row, upper row the column sums
      if (job[1]) red_x = XW'(a[{1'b0, job[0]}]);
      else red_x = XW'(a[job[1:0]]) + XW'(a[job[1:0] + 2'd2]);
    end
    else red_x = XW'(p0) + XW'(p1);
  end

  fmp_modred #(.MOD_BITS(MOD_BITS)) u_red (
    .clk(clk), .rst(rst), .start(red_start), .x(red_x), .m(m),
    .done(red_done), .r(red_r)
  );

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.out_top_left = 31'(a[0]);
  assign out.out_top_right = 31'(a[1]);
  assign out.out_bottom_left = 31'(a[2]);
  assign out.out_bottom_right = 31'(a[3]);
  assign red_start = (state == S_RED);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            b <= in.exponent;
            m <= in.modulus;
            g[0] <= in.given_top_left;
            g[1] <= in.given_top_right;
            g[2] <= in.given_bottom_left;
            g[3] <= in.given_bottom_right;
            bit_idx <= BW'(EXP_BITS - 1);
            job <= '0;
            phase_mul <= 1'b0;
            direct <= 1'b0;
            state <= S_TOP;
          end
        end
        S_TOP: begin
          // catch b == 0, m == 0 and b == 1, else find the top set bit one position per cycle
          if (m == '0 || b == '0) begin
            for (int i = 0; i < 4; i++) a[i] <= '0;
            state <= S_OUT;
          end else if (b == EXP_BITS'(1)) begin
            direct <= 1'b1;
            state <= S_LOAD;
          end else if (b[bit_idx]) begin
            a[0] <= MW'(1); a[1] <= MW'(1); a[2] <= MW'(1); a[3] <= '0;
            bit_idx <= bit_idx - 1'b1;
            state <= S_LOAD;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        S_LOAD: begin
          // products of the current job settle in p0/p1
          state <= S_RED;
        end
        S_RED: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (red_done) begin
            na[job[1:0]] <= red_r;
            if (job != 3'd3) begin
              job <= job + 3'd1;
              state <= S_LOAD;
            end else begin
              job <= '0;
              for (int i = 0; i < 4; i++) a[i] <= (i == 3) ? red_r : na[i];
              if (direct) begin
                state <= S_OUT;
              end else if (!phase_mul && b[bit_idx]) begin
                phase_mul <= 1'b1;
                job <= 3'd0;
                state <= S_LOAD;
              end else begin
                phase_mul <= 1'b0;
                if (bit_idx == '0) state <= S_OUT;
                else begin
                  bit_idx <= bit_idx - 1'b1;
                  state <= S_LOAD;
                end
              end
            end
          end
        end
        S_OUT: begin
          if (out.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !out.valid) else $error("ready while holding result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid) else $error("result dropped");
  a_after_out: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.ready |=> in.ready) else $error("no return to idle");
`endif
endmodule
